@@ hdl/pcfc_pkg.sv @@
// Package: shared types, layout codes and luma weights for the pixel format converter.
`default_nettype none
package pcfc_pkg;

    localparam int unsigned LANE_W = 8;
    localparam int unsigned CODE_W = 3;
    localparam int unsigned IDX_W  = 2;

    // Luma weights, sum of weights is 256
    localparam logic [6:0] LUMA_R = 7'd77;
    localparam logic [7:0] LUMA_G = 8'd150;
    localparam logic [4:0] LUMA_B = 5'd29;
    localparam int unsigned LUMA_SHIFT = 8;
    localparam logic [LANE_W-1:0] OPAQUE = 8'd255;

    // Register indexes of the configuration port
    localparam logic [IDX_W-1:0] REG_SOURCE_CHANNELS = 2'd0;
    localparam logic [IDX_W-1:0] REG_DEST_CHANNELS   = 2'd1;

    typedef enum logic [CODE_W-1:0] {
        LAYOUT_GRAY       = 3'd1,
        LAYOUT_GRAY_ALPHA = 3'd2,
        LAYOUT_RGB        = 3'd3,
        LAYOUT_RGBA       = 3'd4
    } layout_t;

    localparam logic [CODE_W-1:0] LAYOUT_RESET = 3'd4;

    typedef struct packed {
        logic [LANE_W-1:0] in_lane0;
        logic [LANE_W-1:0] in_lane1;
        logic [LANE_W-1:0] in_lane2;
        logic [LANE_W-1:0] in_lane3;
    } in_item_t;

    typedef struct packed {
        logic [LANE_W-1:0] out_lane0;
        logic [LANE_W-1:0] out_lane1;
        logic [LANE_W-1:0] out_lane2;
        logic [LANE_W-1:0] out_lane3;
    } out_item_t;

    typedef struct packed {
        logic [LANE_W-1:0] r;
        logic [LANE_W-1:0] g;
        logic [LANE_W-1:0] b;
        logic [LANE_W-1:0] a;
    } rgba_t;

    // Stage 1 -> 2: widened pixel
    typedef struct packed {
        logic    valid;
        layout_t dst;
        rgba_t   px;
    } expand_stage_t;

    // Stage 2 -> 3: weighted channels
    typedef struct packed {
        logic        valid;
        layout_t     dst;
        rgba_t       px;
        logic [14:0] prod_r;
        logic [15:0] prod_g;
        logic [12:0] prod_b;
    } weight_stage_t;

    // Map a raw register code to a layout; unknown codes act as RGBA
    function automatic layout_t to_layout(input logic [CODE_W-1:0] code);
        layout_t lay;
        case (code)
            3'd1:    lay = LAYOUT_GRAY;
            3'd2:    lay = LAYOUT_GRAY_ALPHA;
            3'd3:    lay = LAYOUT_RGB;
            default: lay = LAYOUT_RGBA;
        endcase
        return lay;
    endfunction

endpackage
`default_nettype wire

@@ hdl/pcfc_expand.sv @@
// Stage 1: widen the source pixel to RGBA and decode the destination layout.
`default_nettype none
module pcfc_expand (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire pcfc_pkg::in_item_t          pixel_in,
    input  wire logic [pcfc_pkg::CODE_W-1:0] src_code,
    input  wire logic [pcfc_pkg::CODE_W-1:0] dst_code,
    output      pcfc_pkg::expand_stage_t     stage_out
);
    import pcfc_pkg::*;

    logic    valid_reg;
    layout_t dst_reg;
    rgba_t   px_reg;
    rgba_t   px_next;
    layout_t src_lay;

    always_comb
    begin
        src_lay = to_layout(src_code);
        px_next = '{r: pixel_in.in_lane0, g: pixel_in.in_lane0,
                    b: pixel_in.in_lane0, a: OPAQUE};
        case (src_lay)
            LAYOUT_GRAY:
            begin
                px_next.a = OPAQUE;
            end
            LAYOUT_GRAY_ALPHA:
            begin
                px_next.a = pixel_in.in_lane1;
            end
            LAYOUT_RGB:
            begin
                px_next.g = pixel_in.in_lane1;
                px_next.b = pixel_in.in_lane2;
            end
            default:
            begin
                px_next.g = pixel_in.in_lane1;
                px_next.b = pixel_in.in_lane2;
                px_next.a = pixel_in.in_lane3;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        px_reg  <= px_next;
        dst_reg <= to_layout(dst_code);
    end

    assign stage_out = '{valid: valid_reg, dst: dst_reg, px: px_reg};

endmodule
`default_nettype wire

@@ hdl/pcfc_weight.sv @@
// Stage 2: multiply R, G and B by their luma weights.
`default_nettype none
module pcfc_weight (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire pcfc_pkg::expand_stage_t stage_in,
    output      pcfc_pkg::weight_stage_t stage_out
);
    import pcfc_pkg::*;

    logic        valid_reg;
    layout_t     dst_reg;
    rgba_t       px_reg;
    logic [14:0] prod_r_reg;
    logic [15:0] prod_g_reg;
    logic [12:0] prod_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        dst_reg    <= stage_in.dst;
        px_reg     <= stage_in.px;
        prod_r_reg <= 15'(stage_in.px.r * LUMA_R);
        prod_g_reg <= 16'(stage_in.px.g * LUMA_G);
        prod_b_reg <= 13'(stage_in.px.b * LUMA_B);
    end

    assign stage_out = '{valid: valid_reg, dst: dst_reg, px: px_reg,
                         prod_r: prod_r_reg, prod_g: prod_g_reg, prod_b: prod_b_reg};

endmodule
`default_nettype wire

@@ hdl/pcfc_pack.sv @@
// Stage 3: sum the weighted channels and pack the destination layout.
`default_nettype none
module pcfc_pack (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire pcfc_pkg::weight_stage_t stage_in,
    output      logic                    out_valid,
    output      pcfc_pkg::out_item_t     pixel_out
);
    import pcfc_pkg::*;

    logic              valid_reg;
    out_item_t         item_reg;
    out_item_t         item_next;
    logic [16:0]       luma_sum;
    logic [LANE_W-1:0] luma;

    always_comb
    begin
        luma_sum  = 17'(stage_in.prod_r) + 17'(stage_in.prod_g) + 17'(stage_in.prod_b);
        // Weights sum to 256, so the shifted sum always fits a byte
        luma      = luma_sum[LUMA_SHIFT +: LANE_W];
        item_next = '0;
        case (stage_in.dst)
            LAYOUT_GRAY:
            begin
                item_next.out_lane0 = luma;
            end
            LAYOUT_GRAY_ALPHA:
            begin
                item_next.out_lane0 = luma;
                item_next.out_lane1 = stage_in.px.a;
            end
            LAYOUT_RGB:
            begin
                item_next.out_lane0 = stage_in.px.r;
                item_next.out_lane1 = stage_in.px.g;
                item_next.out_lane2 = stage_in.px.b;
            end
            default:
            begin
                item_next.out_lane0 = stage_in.px.r;
                item_next.out_lane1 = stage_in.px.g;
                item_next.out_lane2 = stage_in.px.b;
                item_next.out_lane3 = stage_in.px.a;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign pixel_out = item_reg;

endmodule
`default_nettype wire

@@ hdl/pixel_channel_format_convert.sv @@
// Top level: pixel channel layout converter (gray, gray+alpha, RGB, RGBA).
// Path: a pixel taken at a clock edge is loaded into the first of three register
//   stages (expand, weight, pack); pixel_out and done come from the last one.
// Throughput: one pixel every clock; busy stays low, the pipeline never stalls.
// Reset: rst_n clears all valid bits at once and sets both layouts to RGBA.
// The receiver cannot stall: each result is on the outputs for one cycle only.
`default_nettype none
module pixel_channel_format_convert (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // Pixel input, command style
    input  wire logic                        start,
    output      logic                        busy,
    input  wire pcfc_pkg::in_item_t          pixel_in,
    // Result strobe and pixel
    output      logic                        done,
    output      pcfc_pkg::out_item_t         pixel_out,
    // Configuration write port
    input  wire logic                        cfg_wr_en,
    input  wire logic [pcfc_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [pcfc_pkg::CODE_W-1:0] cfg_data
);
    import pcfc_pkg::*;

    // Raw layout codes; unknown codes are decoded as RGBA further down
    logic [CODE_W-1:0] src_code_reg;
    logic [CODE_W-1:0] dst_code_reg;

    expand_stage_t expand_stage;
    weight_stage_t weight_stage;

    // Every stage advances every cycle, so a transfer is never held off
    assign busy = 1'b0;

    // Configuration registers; writes to indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_code_reg <= LAYOUT_RESET;
            dst_code_reg <= LAYOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SOURCE_CHANNELS: src_code_reg <= cfg_data;
                REG_DEST_CHANNELS:   dst_code_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Stage 1: widen the source to RGBA, capture the destination layout
    // with the pixel so it travels down the pipe alongside it
    pcfc_expand u_expand (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .pixel_in  (pixel_in),
        .src_code  (src_code_reg),
        .dst_code  (dst_code_reg),
        .stage_out (expand_stage)
    );

    // Stage 2: one narrow multiplier per color channel
    pcfc_weight u_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage_in  (expand_stage),
        .stage_out (weight_stage)
    );

    // Stage 3: add the products, take the luma byte, pack the output lanes
    pcfc_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage_in  (weight_stage),
        .out_valid (done),
        .pixel_out (pixel_out)
    );

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Testbench for the pixel channel layout converter: directed and random pixel transfers.
`timescale 1ns / 100ps
module testbench;
    import pcfc_pkg::*;

    // Clock and run shape
    localparam int unsigned HALF_PERIOD  = 4;
    localparam int unsigned RESET_CYCLES = 4;
    localparam int unsigned PIPE_DEPTH   = 4;     // three register stages plus the output cycle
    localparam int unsigned DRAIN_LIMIT  = 2000;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned PHASE_ITEMS  = 122;

    // Indexes that select no register; writes to them must change nothing
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 2'd3;

    // Layout codes outside the defined set, both treated as RGBA
    localparam logic [CODE_W-1:0] CODE_LOWEST  = 3'd0;
    localparam logic [CODE_W-1:0] CODE_HIGHEST = 3'd7;

    // BT.601 style luma weights (sum 256) and the default alpha
    localparam logic [15:0] WEIGHT_RED   = 16'd77;
    localparam logic [15:0] WEIGHT_GREEN = 16'd150;
    localparam logic [15:0] WEIGHT_BLUE  = 16'd29;
    localparam logic [LANE_W-1:0] FULL_ALPHA = 8'hFF;

    // Idle rates of the sender per phase, in percent of cycles
    localparam int unsigned IDLE_NONE  = 0;
    localparam int unsigned IDLE_HEAVY = 79;
    localparam int unsigned IDLE_MIXED = 30;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    in_item_t            pixel_in;
    logic                done;
    out_item_t           pixel_out;
    logic                cfg_wr_en;
    logic [IDX_W-1:0]    cfg_index;
    logic [CODE_W-1:0]   cfg_data;

    // Layout registers as the block should hold them
    logic [CODE_W-1:0]   src_code_q;
    logic [CODE_W-1:0]   dst_code_q;

    // Converted pixels still owed by the block, oldest first
    out_item_t           pending_pixels[$];
    int unsigned         mismatch_count = 0;
    int unsigned         idle_pct = IDLE_NONE;

    always #HALF_PERIOD clk = ~clk;

    pixel_channel_format_convert i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel_in  (pixel_in),
        .done      (done),
        .pixel_out (pixel_out),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Widen the source pixel to RGBA, then form the destination layout.
    // Codes outside 1..3 select RGBA on either side; lanes past the
    // destination channel count stay zero.
    function automatic out_item_t convert_pixel(input in_item_t px,
                                                input logic [CODE_W-1:0] src_code,
                                                input logic [CODE_W-1:0] dst_code);
        layout_t           src_lay;
        layout_t           dst_lay;
        logic [LANE_W-1:0] red;
        logic [LANE_W-1:0] green;
        logic [LANE_W-1:0] blue;
        logic [LANE_W-1:0] alpha;
        logic [15:0]       weighted;
        out_item_t         res;
        src_lay = (src_code >= LAYOUT_GRAY && src_code <= LAYOUT_RGB) ?
                  layout_t'(src_code) : LAYOUT_RGBA;
        dst_lay = (dst_code >= LAYOUT_GRAY && dst_code <= LAYOUT_RGB) ?
                  layout_t'(dst_code) : LAYOUT_RGBA;
        alpha = FULL_ALPHA;
        if (src_lay == LAYOUT_GRAY || src_lay == LAYOUT_GRAY_ALPHA) begin
            red   = px.in_lane0;
            green = px.in_lane0;
            blue  = px.in_lane0;
            if (src_lay == LAYOUT_GRAY_ALPHA)
                alpha = px.in_lane1;
        end
        else begin
            red   = px.in_lane0;
            green = px.in_lane1;
            blue  = px.in_lane2;
            if (src_lay == LAYOUT_RGBA)
                alpha = px.in_lane3;
        end
        res = '0;
        if (dst_lay == LAYOUT_GRAY || dst_lay == LAYOUT_GRAY_ALPHA) begin
            // Max sum is 256 * 255, so 16 bits hold it and the top byte is the luma
            weighted = WEIGHT_RED * red + WEIGHT_GREEN * green + WEIGHT_BLUE * blue;
            res.out_lane0 = weighted[15:8];
            if (dst_lay == LAYOUT_GRAY_ALPHA)
                res.out_lane1 = alpha;
        end
        else begin
            res.out_lane0 = red;
            res.out_lane1 = green;
            res.out_lane2 = blue;
            if (dst_lay == LAYOUT_RGBA)
                res.out_lane3 = alpha;
        end
        return res;
    endfunction

    // Random pixel; now and then pin lanes to all-zero or all-one bytes
    function automatic in_item_t random_pixel();
        in_item_t px;
        px = in_item_t'($urandom);
        if ($urandom_range(9) == 0) px.in_lane0 = $urandom_range(1) ? 8'hFF : 8'h00;
        if ($urandom_range(9) == 0) px.in_lane1 = $urandom_range(1) ? 8'hFF : 8'h00;
        if ($urandom_range(9) == 0) px.in_lane2 = $urandom_range(1) ? 8'hFF : 8'h00;
        if ($urandom_range(9) == 0) px.in_lane3 = $urandom_range(1) ? 8'hFF : 8'h00;
        return px;
    endfunction

    // Track register writes and predict every accepted pixel transfer.
    // Sample at the edge, so the values seen are those of the closing cycle.
    always @(posedge clk) begin
        if (!rst_n) begin
            src_code_q <= LAYOUT_RGBA;
            dst_code_q <= LAYOUT_RGBA;
        end
        else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_SOURCE_CHANNELS)
                    src_code_q <= cfg_data;
                else if (cfg_index == REG_DEST_CHANNELS)
                    dst_code_q <= cfg_data;
            end
            if (start && !busy)
                pending_pixels = {pending_pixels,
                                  convert_pixel(pixel_in, src_code_q, dst_code_q)};
        end
    end

    task automatic check_lane(input string lane, input logic [LANE_W-1:0] want,
                              input logic [LANE_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s expected %02h, got %02h", $time, lane, want, got);
        end
    endtask

    // Compare each result transfer with the oldest prediction
    always @(posedge clk) begin
        out_item_t want;
        if (rst_n && done) begin
            if (pending_pixels.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result %08h", $time, pixel_out);
            end
            else begin
                want = pending_pixels.pop_front();
                check_lane("out_lane0", want.out_lane0, pixel_out.out_lane0);
                check_lane("out_lane1", want.out_lane1, pixel_out.out_lane1);
                check_lane("out_lane2", want.out_lane2, pixel_out.out_lane2);
                check_lane("out_lane3", want.out_lane3, pixel_out.out_lane3);
            end
        end
    end

    // Offer one pixel and hold it until the block takes it. Idle first at the
    // current rate, putting junk on the pixel bus while start is low. Leave
    // start high afterwards so back-to-back transfers never drop it.
    task automatic send_pixel(input in_item_t px);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start    <= 1'b0;
            pixel_in <= in_item_t'($urandom);
            @(posedge clk);
        end
        start    <= 1'b1;
        pixel_in <= px;
        do @(posedge clk); while (busy);
    endtask

    // Drop start and hold until every predicted result has come out
    task automatic wait_idle();
        int unsigned guard;
        guard = 0;
        start <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge clk);
            guard++;
        end
    endtask

    // Write both layouts while idle, then a write to a spare index that
    // must leave them alone
    task automatic set_layouts(input logic [CODE_W-1:0] src, input logic [CODE_W-1:0] dst);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SOURCE_CHANNELS;
        cfg_data  <= src;
        @(posedge clk);
        cfg_index <= REG_DEST_CHANNELS;
        cfg_data  <= dst;
        @(posedge clk);
        cfg_index <= $urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO;
        cfg_data  <= CODE_W'($urandom);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // RGBA to RGBA out of reset: extremes and alternating bit patterns
    task automatic test_reset_layout();
        send_pixel('0);
        send_pixel('1);
        send_pixel(32'h5AA5_5AA5);
        send_pixel(32'hA55A_0FF0);
    endtask

    // Every pair of defined layouts, one pixel each
    task automatic test_layout_pairs();
        for (int s = LAYOUT_GRAY; s <= LAYOUT_RGBA; s++) begin
            for (int d = LAYOUT_GRAY; d <= LAYOUT_RGBA; d++) begin
                set_layouts(CODE_W'(s), CODE_W'(d));
                send_pixel(random_pixel());
            end
        end
    endtask

    // Undefined codes act as RGBA; equal R, G and B give that value as luma;
    // white gray stays white through the luma path
    task automatic test_special_codes();
        set_layouts(CODE_LOWEST, CODE_HIGHEST);
        send_pixel(random_pixel());
        set_layouts(CODE_HIGHEST, CODE_LOWEST);
        send_pixel(random_pixel());
        set_layouts(LAYOUT_RGB, LAYOUT_GRAY);
        send_pixel(32'hC3C3_C35A);
        set_layouts(LAYOUT_GRAY, LAYOUT_GRAY_ALPHA);
        send_pixel(32'hFF12_3456);
    endtask

    // Random pixels in runs under random layout codes, all eight values
    // allowed; each run change waits for the pipeline to empty
    task automatic test_random(input int unsigned pct);
        int unsigned sent;
        int unsigned run_len;
        idle_pct = pct;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            set_layouts(CODE_W'($urandom), CODE_W'($urandom));
            run_len = $urandom_range(20, 60);
            for (int unsigned k = 0; k < run_len && sent < PHASE_ITEMS; k++) begin
                send_pixel(random_pixel());
                sent++;
            end
        end
        idle_pct = IDLE_NONE;
    endtask

    // Hold back mid-stream until the block has delivered everything
    task automatic test_pause();
        for (int k = 0; k < 6; k++)
            send_pixel(random_pixel());
        wait_idle();
        for (int k = 0; k < 6; k++)
            send_pixel(random_pixel());
    endtask

    initial begin
        rst_n     = 1'b0;
        start     = 1'b0;
        pixel_in  = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_SOURCE_CHANNELS;
        cfg_data  = LAYOUT_RGBA;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_layout();
        test_layout_pairs();
        test_special_codes();
        test_random(IDLE_NONE);
        test_random(IDLE_HEAVY);
        test_random(IDLE_MIXED);
        test_pause();

        // Let the pipeline empty, then give stray results time to show up
        wait_idle();
        repeat (PIPE_DEPTH + 2) @(posedge clk);
        if (pending_pixels.size() != 0) begin
            $display("%0d predicted results never arrived", pending_pixels.size());
            mismatch_count += pending_pixels.size();
        end
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ pixel_channel_format_convert.f @@
hdl/pcfc_pkg.sv
hdl/pcfc_expand.sv
hdl/pcfc_weight.sv
hdl/pcfc_pack.sv
hdl/pixel_channel_format_convert.sv
tb/testbench.sv
